// ----- sv/page_pool_free_list_top_assert.svh -----
// ----------------------------------------------------------------------------
// Page pool free list: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PAGE_POOL_FREE_LIST_TOP_ASSERT_SVH
`define PAGE_POOL_FREE_LIST_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPFL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("page pool free list check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("page pool free list check failed");

`endif

// ----- sv/ppfl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page pool free list: package
// Item types, operation and status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ppfl_pkg;

	typedef enum logic [1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_FREE    = 2'd1,
		KIND_REBUILD = 2'd2,
		KIND_NOP     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_NOFIT   = 2'd2,
		ST_OUTSIDE = 2'd3
	} status_t;

	typedef enum logic {
		REG_POOL_BASE  = 1'b0,
		REG_POOL_PAGES = 1'b1
	} reg_idx_t;

	localparam int ADDR_W      = 3;
	localparam int REG_IDX_LSB = 2;
	localparam int PAGES_W     = 7;
	localparam logic [PAGES_W-1:0] POOL_PAGES_RST = 7'd64;

	typedef struct packed {
		logic [1:0]  kind;
		logic [8:0]  request_bytes;
		logic [3:0]  align_log;
		logic [31:0] free_address;
	} in_item_t;

	typedef struct packed {
		logic [31:0] grant_address;
		logic [1:0]  status;
	} out_item_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_ALLOC_RD,
		S_ALLOC_POP,
		S_FREE,
		S_NOP,
		S_REBUILD
	} state_t;

	typedef struct packed {
		logic load_item;
		logic load_active;
		logic sweep_write;
		logic head_init;
		logic emit_rebuild;
		logic alloc_read;
		logic alloc_pop;
		logic free_exec;
		logic nop_emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_last;
	} dp_stat_t;

endpackage

// ----- sv/ppfl_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page pool free list: configuration registers
// APB-style register file holding the pool base address and page count.
// ----------------------------------------------------------------------------
module ppfl_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ppfl_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [31:0]                 pool_base,
	output logic [ppfl_pkg::PAGES_W-1:0] pool_pages
);

	logic                         wr_en;
	ppfl_pkg::reg_idx_t           reg_idx;
	logic [31:0]                  pool_base_q;
	logic [ppfl_pkg::PAGES_W-1:0] pool_pages_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = ppfl_pkg::reg_idx_t'(paddr[ppfl_pkg::REG_IDX_LSB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= '0;
			pool_pages_q <= ppfl_pkg::POOL_PAGES_RST;
		end else if (wr_en) begin
			case (reg_idx)
				ppfl_pkg::REG_POOL_BASE:  pool_base_q  <= pwdata;
				ppfl_pkg::REG_POOL_PAGES: pool_pages_q <= pwdata[ppfl_pkg::PAGES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ppfl_pkg::REG_POOL_BASE:  prdata = pool_base_q;
			ppfl_pkg::REG_POOL_PAGES: prdata = {{(32-ppfl_pkg::PAGES_W){1'b0}}, pool_pages_q};
			default:                  prdata = '0;
		endcase
	end

	assign pool_base  = pool_base_q;
	assign pool_pages = pool_pages_q;

endmodule

// ----- sv/ppfl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page pool free list: controller
// Sequences allocate, free, rebuild, the unused no-op code and the table sweep after reset.
// ----------------------------------------------------------------------------
module ppfl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          kind,
	input  ppfl_pkg::dp_stat_t  stat,
	output ppfl_pkg::ctrl_cmd_t cmd,
	output logic                busy
);

	ppfl_pkg::state_t state_q;
	ppfl_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppfl_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ppfl_pkg::S_INIT: begin
				cmd.sweep_write = 1'b1;
				if (stat.sweep_last) begin
					state_d = ppfl_pkg::S_IDLE;
				end
			end
			ppfl_pkg::S_IDLE: begin
				if (start) begin
					cmd.load_item = 1'b1;
					case (ppfl_pkg::kind_t'(kind))
						ppfl_pkg::KIND_ALLOC: state_d = ppfl_pkg::S_ALLOC_RD;
						ppfl_pkg::KIND_FREE:  state_d = ppfl_pkg::S_FREE;
						ppfl_pkg::KIND_REBUILD: begin
							cmd.load_active = 1'b1;
							state_d         = ppfl_pkg::S_REBUILD;
						end
						default: state_d = ppfl_pkg::S_NOP;
					endcase
				end
			end
			ppfl_pkg::S_ALLOC_RD: begin
				cmd.alloc_read = 1'b1;
				state_d        = ppfl_pkg::S_ALLOC_POP;
			end
			ppfl_pkg::S_ALLOC_POP: begin
				cmd.alloc_pop = 1'b1;
				state_d       = ppfl_pkg::S_IDLE;
			end
			ppfl_pkg::S_FREE: begin
				cmd.free_exec = 1'b1;
				state_d       = ppfl_pkg::S_IDLE;
			end
			ppfl_pkg::S_NOP: begin
				cmd.nop_emit = 1'b1;
				state_d      = ppfl_pkg::S_IDLE;
			end
			ppfl_pkg::S_REBUILD: begin
				cmd.sweep_write = 1'b1;
				if (stat.sweep_last) begin
					cmd.head_init    = 1'b1;
					cmd.emit_rebuild = 1'b1;
					state_d          = ppfl_pkg::S_IDLE;
				end
			end
			default: state_d = ppfl_pkg::S_INIT;
		endcase
	end

	assign busy = (state_q != ppfl_pkg::S_IDLE);

endmodule

// ----- sv/ppfl_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page pool free list: datapath
// Next-page table, head pointer, alignment and range arithmetic, result
// register.
// ----------------------------------------------------------------------------
module ppfl_dp #(
	parameter int NUM_PAGES  = 64,
	parameter int PAGE_BYTES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ppfl_pkg::ctrl_cmd_t          cmd,
	input  ppfl_pkg::in_item_t           item,
	input  logic [31:0]                  pool_base,
	input  logic [ppfl_pkg::PAGES_W-1:0] pool_pages,
	output ppfl_pkg::dp_stat_t           stat,
	output logic                         done,
	output ppfl_pkg::out_item_t          result
);

	localparam int PW       = $clog2(NUM_PAGES);
	localparam int AW       = $clog2(NUM_PAGES + 1);
	localparam int PAGE_LOG = $clog2(PAGE_BYTES);
	localparam int ACT_RST  = (NUM_PAGES < 64) ? NUM_PAGES : 64;

	// Each table entry is a valid bit above the index of the next page.
	logic [PW:0]         mem [NUM_PAGES];
	logic [PW:0]         rd_q;

	ppfl_pkg::in_item_t  item_q;
	logic [AW-1:0]       active_q;
	logic [PW-1:0]       head_q;
	logic                head_valid_q;
	logic [PW-1:0]       sweep_q;
	logic [31:0]         aligned_s1;
	logic                fit_s1;
	logic                done_q;
	ppfl_pkg::out_item_t result_q;
	ppfl_pkg::out_item_t result_d;

	logic [AW-1:0]       clamp_pages;
	logic [PW:0]         sw_inc;
	logic                sw_valid;
	logic [PW-1:0]       sw_next;
	logic                we;
	logic [PW-1:0]       waddr;
	logic [PW:0]         wdata;

	logic [32:0]         page_addr;
	logic [15:0]         amask;
	logic [33:0]         amask_ext;
	logic [33:0]         round_sum;
	logic [33:0]         aligned;
	logic [33:0]         offset;
	logic [17:0]         need;
	logic                fit;

	logic [31:0]         faddr;
	logic                is_null;
	logic                below;
	logic                above;
	logic [33:0]         hi;
	logic [31:0]         diff;
	logic [PW-1:0]       free_pg;
	logic                free_push;

	always_comb begin
		if (pool_pages == '0) begin
			clamp_pages = AW'(1);
		end else if ({25'b0, pool_pages} > 32'(NUM_PAGES)) begin
			clamp_pages = AW'(NUM_PAGES);
		end else begin
			clamp_pages = AW'(pool_pages);
		end
	end

	// Sweep entry: link to the following page while it is still in use.
	assign sw_inc   = {1'b0, sweep_q} + (PW+1)'(1);
	assign sw_valid = sw_inc < (PW+1)'(active_q);
	assign sw_next  = sw_valid ? sw_inc[PW-1:0] : '0;
	assign stat.sweep_last = (sweep_q == PW'(NUM_PAGES - 1));

	// Alignment of the head page's address.
	assign page_addr = {1'b0, pool_base} + (33'(head_q) << PAGE_LOG);
	assign amask     = (16'd1 << item_q.align_log) - 16'd1;
	assign amask_ext = {18'b0, amask};
	assign round_sum = {1'b0, page_addr} + amask_ext;
	assign aligned   = round_sum & ~amask_ext;
	assign offset    = aligned - {1'b0, page_addr};
	assign need      = {2'b0, offset[15:0]} + {9'b0, item_q.request_bytes};
	assign fit       = need <= 18'(PAGE_BYTES);

	// Range check and page index of a freed address.
	assign faddr     = item_q.free_address;
	assign is_null   = (faddr == '0);
	assign below     = faddr < pool_base;
	assign hi        = {2'b0, pool_base} + (34'(active_q) << PAGE_LOG);
	assign above     = {2'b0, faddr} >= hi;
	assign diff      = faddr - pool_base;
	assign free_pg   = PW'(diff >> PAGE_LOG);
	assign free_push = cmd.free_exec & ~is_null & ~below & ~above;

	assign we    = cmd.sweep_write | free_push;
	assign waddr = cmd.sweep_write ? sweep_q : free_pg;
	assign wdata = cmd.sweep_write ? {sw_valid, sw_next} : {head_valid_q, head_q};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.alloc_read) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
		if (cmd.alloc_read) begin
			aligned_s1 <= aligned[31:0];
			fit_s1     <= fit;
		end
		result_q <= result_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= AW'(ACT_RST);
			head_q       <= '0;
			head_valid_q <= 1'b1;
			sweep_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			if (cmd.load_active) begin
				active_q <= clamp_pages;
			end
			if (cmd.sweep_write) begin
				sweep_q <= stat.sweep_last ? '0 : sweep_q + PW'(1);
			end
			if (cmd.head_init) begin
				head_q       <= '0;
				head_valid_q <= 1'b1;
			end else if (cmd.alloc_pop && head_valid_q && fit_s1) begin
				head_valid_q <= rd_q[PW];
				head_q       <= rd_q[PW] ? rd_q[PW-1:0] : '0;
			end else if (free_push) begin
				head_q       <= free_pg;
				head_valid_q <= 1'b1;
			end
			done_q <= cmd.alloc_pop | cmd.free_exec | cmd.nop_emit | cmd.emit_rebuild;
		end
	end

	always_comb begin
		result_d.grant_address = '0;
		result_d.status        = ppfl_pkg::ST_OK;
		if (cmd.alloc_pop) begin
			if (!head_valid_q) begin
				result_d.status = ppfl_pkg::ST_EMPTY;
			end else if (!fit_s1) begin
				result_d.status = ppfl_pkg::ST_NOFIT;
			end else begin
				result_d.grant_address = aligned_s1;
			end
		end else if (cmd.free_exec && !is_null && (below || above)) begin
			result_d.status = ppfl_pkg::ST_OUTSIDE;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- sv/page_pool_free_list_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page pool free list
// Fixed-size page allocator kept as a singly linked free list in a table.
// ----------------------------------------------------------------------------
// An item is issued by raising start with the item fields while busy is low;
// it is taken at that clock edge. Kinds are allocate, free, rebuild and an
// unused code that only answers ok. Exactly one result follows each item, on
// result for a single cycle with done high; the receiver cannot stall it.
// From accept to done, an allocate reads the next-page table into a register
// and then pops, free and the unused code each run an execute state, and a
// rebuild runs the table sweep that writes one entry a cycle. busy drops in
// the cycle done rises, so a new item may be issued alongside a result.
// After reset the table is relinked by the same sweep with busy high;
// configuration writes are taken throughout.
// pool_base is used live; pool_pages is applied by reset and by a rebuild.
// PAGE_BYTES must be a power of two.
// ----------------------------------------------------------------------------
`include "page_pool_free_list_top_assert.svh"

module page_pool_free_list_top #(
	parameter int NUM_PAGES  = 64,
	parameter int PAGE_BYTES = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  ppfl_pkg::in_item_t          item,
	output logic                        done,
	output ppfl_pkg::out_item_t         result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ppfl_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	ppfl_pkg::ctrl_cmd_t          cmd;
	ppfl_pkg::dp_stat_t           stat;
	logic [31:0]                  pool_base;
	logic [ppfl_pkg::PAGES_W-1:0] pool_pages;

	ppfl_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.pool_base  (pool_base),
		.pool_pages (pool_pages)
	);

	ppfl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ppfl_dp #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item       (item),
		.pool_base  (pool_base),
		.pool_pages (pool_pages),
		.stat       (stat),
		.done       (done),
		.result     (result)
	);

	// A result only ever closes work that was in flight.
	`PPFL_ASSERT_SAME(a_done_after_busy, clk, arst_n, done, $past(busy))
	// An accepted item keeps the block busy in the following cycle.
	`PPFL_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// Only a successful allocate carries a non-zero address.
	`PPFL_ASSERT_SAME(a_fail_no_grant, clk, arst_n, done && (result.status != ppfl_pkg::ST_OK), result.grant_address == 32'd0)

endmodule
